FILE: rtl/core/morse_keyer_core_assert.svh
// Assertion macros for the keyer core, included by mk_back.
`ifndef MORSE_KEYER_CORE_ASSERT_SVH
`define MORSE_KEYER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mk_pkg.sv
package mk_pkg;

    // Width of every timing register and of an interval duration
    localparam int DUR_W    = 6;
    localparam int CHAR_W   = 8;
    localparam int MAX_ELEM = 5;
    localparam int ELEM_W   = 3;
    // Interval index within a run: up to two per element plus the closing gap
    localparam int IDX_W    = 4;

    // Descriptor queue between front and back (power of two, pointers wrap)
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DOT_ON   = 3'd0,
        REG_DASH_ON  = 3'd1,
        REG_ELEM_GAP = 3'd2,
        REG_CHAR_GAP = 3'd3,
        REG_WORD_GAP = 3'd4
    } t_reg_idx;

    // Reset values of the timing registers
    localparam logic [DUR_W-1:0] RST_DOT_ON   = 6'd3;
    localparam logic [DUR_W-1:0] RST_DASH_ON  = 6'd9;
    localparam logic [DUR_W-1:0] RST_ELEM_GAP = 6'd1;
    localparam logic [DUR_W-1:0] RST_CHAR_GAP = 6'd3;
    localparam logic [DUR_W-1:0] RST_WORD_GAP = 6'd7;

    // Character codes of interest
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;

    // Classified character: element count and pattern, bit i set for a dash
    typedef struct packed {
        logic                is_space;
        logic [ELEM_W-1:0]   n_elem;
        logic [MAX_ELEM-1:0] pattern;
    } t_desc;

    // Live timing register set
    typedef struct packed {
        logic [DUR_W-1:0] dot_on;
        logic [DUR_W-1:0] dash_on;
        logic [DUR_W-1:0] elem_gap;
        logic [DUR_W-1:0] char_gap;
        logic [DUR_W-1:0] word_gap;
    } t_timing;

    // Letter symbols A..Z, first element in bit 0
    localparam logic [MAX_ELEM-1:0] LETTER_PAT [26] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011
    };
    localparam logic [ELEM_W-1:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    // Digit symbols 0..9, all five elements long
    localparam logic [MAX_ELEM-1:0] DIGIT_PAT [10] = '{
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    // Map a character code to its descriptor; unknown codes get no elements
    function automatic t_desc mk_classify(input logic [CHAR_W-1:0] c);
        t_desc      d;
        logic [4:0] li;
        logic [3:0] di;
        d  = '0;
        li = '0;
        di = '0;
        if (c == CHAR_SPACE) begin
            d.is_space = 1'b1;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            li        = 5'(c - CHAR_UP_A);
            d.n_elem  = LETTER_LEN[li];
            d.pattern = LETTER_PAT[li];
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            li        = 5'(c - CHAR_LO_A);
            d.n_elem  = LETTER_LEN[li];
            d.pattern = LETTER_PAT[li];
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            di        = 4'(c - CHAR_ZERO);
            d.n_elem  = ELEM_W'(MAX_ELEM);
            d.pattern = DIGIT_PAT[di];
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/mk_front.sv
module mk_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [mk_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output mk_pkg::t_desc              o_q_desc
);
    import mk_pkg::*;

    logic  r_valid;
    t_desc r_desc;
    logic  accept;

    // Stall the input only while the stage holds a word the queue cannot take
    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_desc = r_desc;

    // Classify each accepted character and hold it until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= mk_classify(i_char_code);
        end
    end

endmodule

FILE: rtl/core/mk_queue.sv
module mk_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mk_pkg::t_desc i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mk_pkg::t_desc o_rdata
);
    import mk_pkg::*;

    t_desc             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: rtl/core/mk_back.sv
`include "morse_keyer_core_assert.svh"

module mk_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mk_pkg::t_timing           i_timing,
    input  logic                      i_q_valid,
    input  mk_pkg::t_desc             i_q_desc,
    output logic                      o_q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_lamp_on,
    output logic [mk_pkg::DUR_W-1:0]  o_duration_units,
    output logic                      o_last_of_run
);
    import mk_pkg::*;

    logic             r_busy;
    t_desc            r_desc;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic             r_lamp;
    logic [DUR_W-1:0] r_dur;
    logic             r_last;

    logic             advance;
    logic             cur_valid;
    t_desc            cur_desc;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] end_idx;
    logic [7:0]       pat8;
    logic             cur_last;
    logic             cur_lamp;
    logic             cur_dash;
    logic [DUR_W-1:0] cur_dur;
    logic             emit;

    // Work on the held run, or start straight from the queue head
    assign advance   = !r_out_valid || pop;
    assign cur_valid = r_busy || i_q_valid;
    assign cur_desc  = r_busy ? r_desc : i_q_desc;
    assign cur_idx   = r_busy ? r_idx : '0;
    assign end_idx   = {cur_desc.n_elem, 1'b0};
    assign pat8      = {{(8-MAX_ELEM){1'b0}}, cur_desc.pattern};
    assign emit      = advance && cur_valid;
    assign o_q_pop   = advance && !r_busy && i_q_valid;

    // Select the interval: lit element, element gap, then closing gap
    always_comb begin
        cur_last = cur_desc.is_space || (cur_idx == end_idx);
        cur_lamp = !cur_last && !cur_idx[0];
        cur_dash = pat8[cur_idx[IDX_W-1:1]];
        if (cur_desc.is_space) begin
            cur_dur = i_timing.word_gap;
        end else if (cur_last) begin
            cur_dur = i_timing.char_gap;
        end else if (!cur_lamp) begin
            cur_dur = i_timing.elem_gap;
        end else if (cur_dash) begin
            cur_dur = i_timing.dash_on;
        end else begin
            cur_dur = i_timing.dot_on;
        end
    end

    // Step through the run and keep the output register full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (cur_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the run descriptor, index and the waiting interval
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_desc <= cur_desc;
            r_idx  <= cur_idx + 1'b1;
            r_lamp <= cur_lamp;
            r_dur  <= cur_dur;
            r_last <= cur_last;
        end
    end

    assign empty            = !r_out_valid;
    assign o_lamp_on        = r_lamp;
    assign o_duration_units = r_dur;
    assign o_last_of_run    = r_last;

    `MK_ASSERT_NOW(a_busy_not_space, r_busy, !r_desc.is_space, "space run left busy")
    `MK_ASSERT_NOW(a_idx_in_run, r_busy, (r_idx != '0) && (r_idx <= {r_desc.n_elem, 1'b0}), "run index out of range")
    `MK_ASSERT_NOW(a_last_is_dark, r_out_valid && r_last, !r_lamp, "final interval lit")
    `MK_ASSERT_NEXT(a_pop_only_idle, o_q_pop && !cur_last, r_busy, "new run not held")

endmodule

FILE: rtl/core/morse_keyer_core.sv
// The first interval of a character passes the front stage, the queue and the mk_back output
// register on its way to the result ports. A character gives 2*n+1 intervals for n Morse elements
// (1 to 5), one interval per cycle while pop stays high; the interval sequencer in mk_back sets this.
// Characters behind the running one wait in a front stage and a 2-word queue.
// Reset (synchronous, active low) empties all stages and loads the default timings.
module morse_keyer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mk_pkg::CHAR_W-1:0]     i_char_code,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_lamp_on,
    output logic [mk_pkg::DUR_W-1:0]      o_duration_units,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_we,
    input  logic [mk_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mk_pkg::DUR_W-1:0]      i_cfg_wdata
);
    import mk_pkg::*;

    t_timing r_timing;
    logic    q_full;
    logic    q_push;
    t_desc   q_wdata;
    logic    q_pop;
    logic    q_valid;
    t_desc   q_rdata;

    // Write timing registers; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.dot_on   <= RST_DOT_ON;
            r_timing.dash_on  <= RST_DASH_ON;
            r_timing.elem_gap <= RST_ELEM_GAP;
            r_timing.char_gap <= RST_CHAR_GAP;
            r_timing.word_gap <= RST_WORD_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DOT_ON:   r_timing.dot_on   <= i_cfg_wdata;
                REG_DASH_ON:  r_timing.dash_on  <= i_cfg_wdata;
                REG_ELEM_GAP: r_timing.elem_gap <= i_cfg_wdata;
                REG_CHAR_GAP: r_timing.char_gap <= i_cfg_wdata;
                REG_WORD_GAP: r_timing.word_gap <= i_cfg_wdata;
                default:      r_timing          <= r_timing;
            endcase
        end
    end

    mk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_desc    (q_wdata)
    );

    mk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    mk_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_timing         (r_timing),
        .i_q_valid        (q_valid),
        .i_q_desc         (q_rdata),
        .o_q_pop          (q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_lamp_on        (o_lamp_on),
        .o_duration_units (o_duration_units),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
